@@ rtl/crsc_pkg.sv @@
// Package with shared constants, command codes and types for the catalog record store.
package crsc_pkg;

  localparam int NumRecordsDefault = 1024;
  localparam logic [3:0] UnusedCat = 4'hF;
  localparam logic [7:0] UnusedTag = 8'hF0;
  localparam logic [7:0] NameMark = 8'h24;

  typedef enum logic [3:0] {
    CMD_WRITE      = 4'd0,
    CMD_READ       = 4'd1,
    CMD_FIRST      = 4'd2,
    CMD_NEXT       = 4'd3,
    CMD_PREV       = 4'd4,
    CMD_NAME_REC   = 4'd5,
    CMD_FIRST_FREE = 4'd6,
    CMD_GOTO       = 4'd7,
    CMD_COUNT      = 4'd8,
    CMD_COUNT_ALL  = 4'd9,
    CMD_CLEAR_CUR  = 4'd10,
    CMD_CLEAR_CAT  = 4'd11,
    CMD_CLEAR_ALL  = 4'd12
  } cmd_t;

  // Sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_INIT  = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_WAIT  = 7'b0001000,
    ST_TEST  = 7'b0010000,
    ST_DONE  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  // Classification of one scanned record by the shared test unit.
  typedef struct packed {
    logic member;
    logic named;
    logic in_cat;
    logic used;
    logic free;
  } rec_flags_t;

endpackage

@@ rtl/catalog_record_store_cursor_top.sv @@
// Top level of the catalog record store with cursor and scan sequencer.
// The block holds NUM_RECORDS records in single-port memories and runs one command at a time.
// After reset a clearing pass writes the unused tag into every record, one per cycle, before
// the first command is accepted. A write, an unused command code, a next at the last record
// and a prev at record 0 go from the start state straight to the done state. A read or a
// cursor clear passes once through the wait and test states. Commands that search or count
// walk the store through the shared record test unit, each record visited passing through
// a wait state for the registered read and a test state. A clear of the catalog or of
// everything is a write sweep in which each record passes through the test state, where
// it is written, the sweep step that reads the next record, and the wait state.
// The result is held in an output register until taken; a finished command waits while an
// earlier result is stalled. The sequencer returns to idle as the result is loaded, and
// only in idle is a new command accepted.
module catalog_record_store_cursor_top
  import crsc_pkg::*;
#(
  parameter int NUM_RECORDS = NumRecordsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_catalog,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_cmd,
  input  logic [63:0] in_name_low,
  input  logic [23:0] in_name_high,
  input  logic [3:0]  in_object_class,
  input  logic [15:0] in_ra_code,
  input  logic [15:0] in_dec_code,
  input  logic [10:0] in_record_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [9:0]  out_position,
  output logic [10:0] out_count,
  output logic [10:0] out_free_count,
  output logic [63:0] out_out_name_low,
  output logic [23:0] out_out_name_high,
  output logic [3:0]  out_out_class,
  output logic [15:0] out_out_ra,
  output logic [15:0] out_out_dec
);

  localparam int AW = $clog2(NUM_RECORDS);
  localparam int CW = $clog2(NUM_RECORDS + 1);
  localparam logic [AW-1:0] LastIdx = AW'(NUM_RECORDS - 1);
  localparam logic [CW-1:0] NumRec = CW'(NUM_RECORDS);

  // Record memories.
  logic [63:0] name_low_mem [NUM_RECORDS];
  logic [23:0] name_high_mem [NUM_RECORDS];
  logic [31:0] coord_mem [NUM_RECORDS];
  logic [7:0]  tag_mem [NUM_RECORDS];

  logic [63:0] rd_nl;
  logic [23:0] rd_nh;
  logic [31:0] rd_co;
  logic [7:0]  rd_tag;

  state_t state_r, state_nxt;
  logic [3:0]  catalog_r;
  cmd_t        cmd_r;
  logic [63:0] wnl_r;
  logic [23:0] wnh_r;
  logic [3:0]  wcl_r;
  logic [31:0] wco_r;
  logic [10:0] num_r;
  logic [AW-1:0] cursor_r, cursor_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [10:0] gcnt_r, gcnt_nxt;
  logic ok_r, ok_nxt;
  logic result_load;

  // Memory port controls.
  logic          mem_we;
  logic          mem_full_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_tag;

  rec_flags_t flags;

  logic out_valid_r;
  logic        o_ok_r;
  logic [9:0]  o_pos_r;
  logic [10:0] o_cnt_r, o_free_r;
  logic [63:0] o_nl_r;
  logic [23:0] o_nh_r;
  logic [3:0]  o_cl_r;
  logic [31:0] o_co_r;

  crsc_record_test u_test (
    .tag        (rd_tag),
    .name_byte0 (rd_nl[7:0]),
    .catalog    (catalog_r),
    .flags      (flags)
  );

  // Configuration register; a catalog of 15 is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      catalog_r <= '0;
    end else if (cfg_we && (cfg_catalog != UnusedCat)) begin
      catalog_r <= cfg_catalog;
    end
  end

  // Memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_addr] <= mem_tag;
    end
    if (mem_full_we) begin
      name_low_mem[mem_addr]  <= wnl_r;
      name_high_mem[mem_addr] <= wnh_r;
      coord_mem[mem_addr]     <= wco_r;
    end
    rd_tag <= tag_mem[mem_addr];
    rd_nl  <= name_low_mem[mem_addr];
    rd_nh  <= name_high_mem[mem_addr];
    rd_co  <= coord_mem[mem_addr];
  end

  assign in_stall = (state_r != ST_IDLE);

  logic accept;
  assign accept = in_valid && !in_stall;

  logic scan_cmd;
  always_comb begin
    scan_cmd  = (cmd_r == CMD_FIRST) || (cmd_r == CMD_NEXT) || (cmd_r == CMD_PREV) ||
                (cmd_r == CMD_NAME_REC) || (cmd_r == CMD_FIRST_FREE) ||
                (cmd_r == CMD_GOTO) || (cmd_r == CMD_COUNT) || (cmd_r == CMD_COUNT_ALL);
  end

  // Sequencer: walks addr_r over the store and tests each read record.
  always_comb begin
    state_nxt   = state_r;
    cursor_nxt  = cursor_r;
    addr_nxt    = addr_r;
    cnt_nxt     = cnt_r;
    gcnt_nxt    = gcnt_r;
    ok_nxt      = ok_r;
    mem_we      = 1'b0;
    mem_full_we = 1'b0;
    mem_addr    = addr_r;
    mem_tag     = UnusedTag;
    case (state_r)
      ST_INIT: begin
        mem_we = 1'b1;
        if (addr_r == LastIdx) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        ok_nxt   = 1'b0;
        cnt_nxt  = '0;
        gcnt_nxt = '0;
        addr_nxt = cursor_r;
        if (accept) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        // Set the starting address for the command, or perform the write.
        state_nxt = ST_WAIT;
        case (cmd_r)
          CMD_WRITE: begin
            mem_we      = 1'b1;
            mem_full_we = 1'b1;
            mem_tag     = {catalog_r, wcl_r};
            state_nxt   = ST_DONE;
          end
          CMD_FIRST: begin
            cursor_nxt = '0;
            addr_nxt   = '0;
            mem_addr   = '0;
          end
          CMD_NEXT: begin
            if (cursor_r == LastIdx) begin
              state_nxt = ST_DONE;
            end else begin
              addr_nxt = cursor_r + AW'(1);
              mem_addr = cursor_r + AW'(1);
            end
          end
          CMD_PREV: begin
            if (cursor_r == '0) begin
              state_nxt = ST_DONE;
            end else begin
              addr_nxt = cursor_r - AW'(1);
              mem_addr = cursor_r - AW'(1);
            end
          end
          CMD_NAME_REC, CMD_FIRST_FREE, CMD_GOTO, CMD_COUNT, CMD_COUNT_ALL,
          CMD_CLEAR_CAT, CMD_CLEAR_ALL: begin
            addr_nxt = '0;
            mem_addr = '0;
          end
          CMD_READ, CMD_CLEAR_CUR: begin
            mem_addr = cursor_r;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_WAIT: begin
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        // Record at addr_r is on the read port now.
        state_nxt = ST_WAIT;
        case (cmd_r)
          CMD_READ: begin
            ok_nxt    = flags.in_cat;
            state_nxt = ST_DONE;
          end
          CMD_CLEAR_CUR: begin
            mem_we    = flags.in_cat;
            state_nxt = ST_DONE;
          end
          CMD_FIRST, CMD_NEXT: begin
            cursor_nxt = addr_r;
            if (flags.member) begin
              ok_nxt = 1'b1;
              state_nxt = ST_DONE;
            end else if (addr_r == LastIdx) begin
              state_nxt = ST_DONE;
            end else begin
              addr_nxt = addr_r + AW'(1);
              mem_addr = addr_r + AW'(1);
            end
          end
          CMD_PREV: begin
            cursor_nxt = addr_r;
            if (flags.member) begin
              ok_nxt = 1'b1;
              state_nxt = ST_DONE;
            end else if (addr_r == '0) begin
              state_nxt = ST_DONE;
            end else begin
              addr_nxt = addr_r - AW'(1);
              mem_addr = addr_r - AW'(1);
            end
          end
          CMD_NAME_REC, CMD_FIRST_FREE: begin
            if ((cmd_r == CMD_NAME_REC) ? flags.named : flags.free) begin
              cursor_nxt = addr_r;
              ok_nxt = 1'b1;
              state_nxt = ST_DONE;
            end else if (addr_r == LastIdx) begin
              cursor_nxt = LastIdx;
              state_nxt = ST_DONE;
            end else begin
              addr_nxt = addr_r + AW'(1);
              mem_addr = addr_r + AW'(1);
            end
          end
          CMD_GOTO: begin
            if ((gcnt_r + 11'(flags.member)) == num_r) begin
              cursor_nxt = addr_r;
              ok_nxt = 1'b1;
              state_nxt = ST_DONE;
            end else if (addr_r == LastIdx) begin
              state_nxt = ST_DONE;
            end else begin
              gcnt_nxt = gcnt_r + 11'(flags.member);
              addr_nxt = addr_r + AW'(1);
              mem_addr = addr_r + AW'(1);
            end
          end
          CMD_COUNT, CMD_COUNT_ALL: begin
            if ((cmd_r == CMD_COUNT) ? flags.member : flags.used) begin
              cnt_nxt = cnt_r + CW'(1);
            end
            if (addr_r == LastIdx) begin
              state_nxt = ST_DONE;
            end else begin
              addr_nxt = addr_r + AW'(1);
              mem_addr = addr_r + AW'(1);
            end
          end
          CMD_CLEAR_CAT, CMD_CLEAR_ALL: begin
            mem_we = (cmd_r == CMD_CLEAR_ALL) || flags.in_cat;
            if (addr_r == LastIdx) begin
              state_nxt = ST_DONE;
            end else begin
              addr_nxt = addr_r + AW'(1);
              state_nxt = ST_OUT;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_OUT: begin
        // Sweep step: issue the read of the next record after a write.
        mem_addr  = addr_r;
        state_nxt = ST_WAIT;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      cursor_r <= '0;
      addr_r   <= '0;
      cnt_r    <= '0;
      gcnt_r   <= '0;
      ok_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      addr_r   <= addr_nxt;
      cnt_r    <= cnt_nxt;
      gcnt_r   <= gcnt_nxt;
      ok_r     <= ok_nxt;
    end
  end

  // Captured transaction payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_cmd);
      wnl_r <= in_name_low;
      wnh_r <= in_name_high;
      wcl_r <= in_object_class;
      wco_r <= {in_dec_code, in_ra_code};
      num_r <= in_record_number;
    end
  end

  // The finished command moves into the output register once it is free.
  assign result_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  logic rd_ok;
  assign rd_ok = (cmd_r == CMD_READ) && ok_r;

  always_ff @(posedge clk) begin
    if (result_load) begin
      o_ok_r   <= ok_r;
      o_pos_r  <= 10'(cursor_r);
      o_cnt_r  <= (scan_cmd && (cmd_r == CMD_COUNT || cmd_r == CMD_COUNT_ALL)) ?
                  11'(cnt_r) : 11'd0;
      o_free_r <= (cmd_r == CMD_COUNT_ALL) ? 11'(NumRec - cnt_r) : 11'd0;
      o_nl_r   <= rd_ok ? rd_nl : 64'd0;
      o_nh_r   <= rd_ok ? rd_nh : 24'd0;
      o_cl_r   <= rd_ok ? rd_tag[3:0] : 4'd0;
      o_co_r   <= rd_ok ? rd_co : 32'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = o_ok_r;
  assign out_position      = o_pos_r;
  assign out_count         = o_cnt_r;
  assign out_free_count    = o_free_r;
  assign out_out_name_low  = o_nl_r;
  assign out_out_name_high = o_nh_r;
  assign out_out_class     = o_cl_r;
  assign out_out_ra        = o_co_r[15:0];
  assign out_out_dec       = o_co_r[31:16];

endmodule

@@ rtl/crsc_record_test.sv @@
// Shared record test unit: classifies one record against the catalog register.
module crsc_record_test
  import crsc_pkg::*;
(
  input  logic [7:0]  tag,
  input  logic [7:0]  name_byte0,
  input  logic [3:0]  catalog,
  output rec_flags_t  flags
);

  logic cat_eq;

  // Catalog match and name marker decide membership.
  always_comb begin
    cat_eq       = (tag[7:4] == catalog);
    flags.in_cat = cat_eq;
    flags.member = cat_eq && (name_byte0 != NameMark);
    flags.named  = cat_eq && (name_byte0 == NameMark);
    flags.free   = (tag[7:4] == UnusedCat);
    flags.used   = (tag[7:4] != UnusedCat);
  end

endmodule

@@ test/tb_catalog_record_store_cursor_top.sv @@
// Self-checking testbench for the catalog record store with cursor.
`timescale 1ns / 1ps

module tb_catalog_record_store_cursor_top;
  import crsc_pkg::*;

  localparam int NumRec = 1024;
  localparam int CycleLimit = 12000000;

  typedef struct {
    logic [3:0]  cmd;
    logic [63:0] name_low;
    logic [23:0] name_high;
    logic [3:0]  object_class;
    logic [15:0] ra_code;
    logic [15:0] dec_code;
    logic [10:0] record_number;
  } cmd_item_t;

  typedef struct {
    logic        ok;
    logic [9:0]  position;
    logic [10:0] count;
    logic [10:0] free_count;
    logic [63:0] name_low;
    logic [23:0] name_high;
    logic [3:0]  rec_class;
    logic [15:0] ra;
    logic [15:0] dec;
  } cmd_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_catalog = 4'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_cmd = 4'd0;
  logic [63:0] in_name_low = '0;
  logic [23:0] in_name_high = '0;
  logic [3:0] in_object_class = '0;
  logic [15:0] in_ra_code = '0;
  logic [15:0] in_dec_code = '0;
  logic [10:0] in_record_number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_ok;
  logic [9:0] out_position;
  logic [10:0] out_count, out_free_count;
  logic [63:0] out_out_name_low;
  logic [23:0] out_out_name_high;
  logic [3:0] out_out_class;
  logic [15:0] out_out_ra, out_out_dec;

  catalog_record_store_cursor_top uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_catalog(cfg_catalog),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_name_low(in_name_low), .in_name_high(in_name_high),
    .in_object_class(in_object_class), .in_ra_code(in_ra_code),
    .in_dec_code(in_dec_code), .in_record_number(in_record_number),
    .out_valid(out_valid), .out_stall(out_stall), .out_ok(out_ok),
    .out_position(out_position), .out_count(out_count),
    .out_free_count(out_free_count), .out_out_name_low(out_out_name_low),
    .out_out_name_high(out_out_name_high), .out_out_class(out_out_class),
    .out_out_ra(out_out_ra), .out_out_dec(out_out_dec)
  );

  always #5 clk = ~clk;

  // Shadow copy of the record store, cursor and catalog register.
  logic [63:0] shadow_name_low [NumRec];
  logic [23:0] shadow_name_high [NumRec];
  logic [7:0]  shadow_tag [NumRec];
  logic [31:0] shadow_coord [NumRec];
  logic [9:0]  shadow_cursor;
  logic [3:0]  shadow_catalog;
  // Records written since reset; reads of names are limited to these.
  bit          ever_written [NumRec];

  cmd_item_t   pending_cmds[$];
  cmd_result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int cmds_sent = 0;

  function automatic bit is_member(int i);
    return shadow_tag[i][7:4] == shadow_catalog && shadow_name_low[i][7:0] != NameMark;
  endfunction

  function automatic bit step_forward();
    while (shadow_cursor < NumRec - 1) begin
      shadow_cursor++;
      if (is_member(shadow_cursor)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit step_back();
    while (shadow_cursor > 0) begin
      shadow_cursor--;
      if (is_member(shadow_cursor)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one command to the shadow store and return the result it produces.
  function automatic cmd_result_t apply_cmd(cmd_item_t it);
    cmd_result_t r;
    int c;
    bit hit;
    r = '{default: '0};
    case (it.cmd)
      CMD_WRITE: begin
        shadow_name_low[shadow_cursor] = it.name_low;
        shadow_name_high[shadow_cursor] = it.name_high;
        shadow_tag[shadow_cursor] = {shadow_catalog, it.object_class};
        shadow_coord[shadow_cursor] = {it.dec_code, it.ra_code};
        ever_written[shadow_cursor] = 1'b1;
      end
      CMD_READ: begin
        if (shadow_tag[shadow_cursor][7:4] == shadow_catalog) begin
          r.ok = 1'b1;
          r.name_low = shadow_name_low[shadow_cursor];
          r.name_high = shadow_name_high[shadow_cursor];
          r.rec_class = shadow_tag[shadow_cursor][3:0];
          r.ra = shadow_coord[shadow_cursor][15:0];
          r.dec = shadow_coord[shadow_cursor][31:16];
        end
      end
      CMD_FIRST: begin
        shadow_cursor = '0;
        r.ok = is_member(0) ? 1'b1 : step_forward();
      end
      CMD_NEXT: r.ok = step_forward();
      CMD_PREV: r.ok = step_back();
      CMD_NAME_REC, CMD_FIRST_FREE: begin
        shadow_cursor = 10'(NumRec - 1);
        for (int i = 0; i < NumRec; i++) begin
          hit = (it.cmd == CMD_NAME_REC) ?
            (shadow_tag[i][7:4] == shadow_catalog && shadow_name_low[i][7:0] == NameMark) :
            (shadow_tag[i][7:4] == UnusedCat);
          if (hit) begin
            shadow_cursor = 10'(i);
            r.ok = 1'b1;
            break;
          end
        end
      end
      CMD_GOTO: begin
        c = 0;
        for (int i = 0; i < NumRec; i++) begin
          if (is_member(i)) c++;
          if (c == int'(it.record_number)) begin
            shadow_cursor = 10'(i);
            r.ok = 1'b1;
            break;
          end
        end
      end
      CMD_COUNT: begin
        for (int i = 0; i < NumRec; i++) if (is_member(i)) r.count++;
      end
      CMD_COUNT_ALL: begin
        for (int i = 0; i < NumRec; i++) if (shadow_tag[i][7:4] != UnusedCat) r.count++;
        r.free_count = 11'(NumRec - int'(r.count));
      end
      CMD_CLEAR_CUR: begin
        if (shadow_tag[shadow_cursor][7:4] == shadow_catalog)
          shadow_tag[shadow_cursor] = UnusedTag;
      end
      CMD_CLEAR_CAT: begin
        for (int i = 0; i < NumRec; i++)
          if (shadow_tag[i][7:4] == shadow_catalog) shadow_tag[i] = UnusedTag;
      end
      CMD_CLEAR_ALL: begin
        for (int i = 0; i < NumRec; i++) shadow_tag[i] = UnusedTag;
      end
      default: ;
    endcase
    r.position = shadow_cursor;
    return r;
  endfunction

  function automatic cmd_item_t random_cmd(logic [3:0] cmd);
    cmd_item_t it;
    it.cmd = cmd;
    it.name_low = {$urandom, $urandom};
    if ($urandom_range(0, 5) == 0) it.name_low[7:0] = NameMark;
    it.name_high = 24'($urandom);
    it.object_class = 4'($urandom);
    it.ra_code = 16'($urandom);
    it.dec_code = 16'($urandom);
    it.record_number = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 1024))
                                                    : 11'($urandom_range(0, 12));
    return it;
  endfunction

  // Reads of never-written records would expose undefined names, so a read
  // whose target is unknown is swapped for a first.
  function automatic cmd_item_t safe_cmd(cmd_item_t it);
    if (it.cmd == CMD_READ && !ever_written[shadow_cursor] &&
        shadow_tag[shadow_cursor][7:4] == shadow_catalog) it.cmd = CMD_FIRST;
    return it;
  endfunction

  // Predictions are made when queued, so the store is predicted in order.
  task automatic queue_cmd(cmd_item_t it);
    it = safe_cmd(it);
    pending_cmds.push_back(it);
    expected_results.push_back(apply_cmd(it));
    cmds_sent++;
  endtask

  task automatic idle_pipeline();
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (2 * NumRec + 20) @(posedge clk);
  endtask

  task automatic set_catalog(logic [3:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_catalog <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (value != UnusedCat) shadow_catalog = value;
  endtask

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: presents queued transactions with random gaps.
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        void'(pending_cmds.pop_front());
        in_gap = gap_len();
      end
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        in_valid <= 1'b1;
        in_cmd <= pending_cmds[0].cmd;
        in_name_low <= pending_cmds[0].name_low;
        in_name_high <= pending_cmds[0].name_high;
        in_object_class <= pending_cmds[0].object_class;
        in_ra_code <= pending_cmds[0].ra_code;
        in_dec_code <= pending_cmds[0].dec_code;
        in_record_number <= pending_cmds[0].record_number;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  int stall_left = 0;
  always @(posedge clk) begin
    cmd_result_t e;
    cycles++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_ok !== e.ok) begin
            $error("ok exp %0d got %0d", e.ok, out_ok); errors++;
          end
          if (out_position !== e.position) begin
            $error("position exp %0d got %0d", e.position, out_position); errors++;
          end
          if (out_count !== e.count) begin
            $error("count exp %0d got %0d", e.count, out_count); errors++;
          end
          if (out_free_count !== e.free_count) begin
            $error("free_count exp %0d got %0d", e.free_count, out_free_count); errors++;
          end
          if (out_out_name_low !== e.name_low) begin
            $error("out_name_low exp %h got %h", e.name_low, out_out_name_low); errors++;
          end
          if (out_out_name_high !== e.name_high) begin
            $error("out_name_high exp %h got %h", e.name_high, out_out_name_high); errors++;
          end
          if (out_out_class !== e.rec_class) begin
            $error("out_class exp %0d got %0d", e.rec_class, out_out_class); errors++;
          end
          if (out_out_ra !== e.ra) begin
            $error("out_ra exp %h got %h", e.ra, out_out_ra); errors++;
          end
          if (out_out_dec !== e.dec) begin
            $error("out_dec exp %h got %h", e.dec, out_out_dec); errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = (cycles % 4000 < 1000) ? 0 : gap_len();
        out_stall <= (stall_left > 0);
      end
    end
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus: directed cases first, then random phases under several catalogs.
  initial begin
    cmd_item_t it;
    int k;
    for (int i = 0; i < NumRec; i++) begin
      shadow_name_low[i] = '0;
      shadow_name_high[i] = '0;
      shadow_tag[i] = UnusedTag;
      shadow_coord[i] = '0;
      ever_written[i] = 1'b0;
    end
    shadow_cursor = '0;
    shadow_catalog = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, extreme field values, each command.
    queue_cmd(random_cmd(CMD_COUNT_ALL));
    queue_cmd(random_cmd(CMD_FIRST));
    queue_cmd(random_cmd(CMD_READ));
    queue_cmd(random_cmd(CMD_FIRST_FREE));
    it = random_cmd(CMD_WRITE);
    it.name_low = '1; it.name_high = '1; it.object_class = '1;
    it.ra_code = '1; it.dec_code = '1;
    queue_cmd(it);
    queue_cmd(random_cmd(CMD_READ));
    queue_cmd(random_cmd(CMD_NEXT));
    it = random_cmd(CMD_WRITE);
    it.name_low = '0; it.name_high = '0; it.object_class = '0;
    it.ra_code = '0; it.dec_code = '0;
    queue_cmd(it);
    queue_cmd(random_cmd(CMD_READ));
    queue_cmd(random_cmd(CMD_PREV));
    queue_cmd(random_cmd(CMD_FIRST_FREE));
    it = random_cmd(CMD_WRITE); it.name_low[7:0] = NameMark;
    queue_cmd(it);
    queue_cmd(random_cmd(CMD_READ));
    queue_cmd(random_cmd(CMD_NAME_REC));
    queue_cmd(random_cmd(CMD_COUNT));
    it = random_cmd(CMD_GOTO); it.record_number = '0; queue_cmd(it);
    it = random_cmd(CMD_GOTO); it.record_number = 11'd1; queue_cmd(it);
    it = random_cmd(CMD_GOTO); it.record_number = 11'd1024; queue_cmd(it);
    it = random_cmd(CMD_GOTO); it.record_number = '1; queue_cmd(it);
    queue_cmd(random_cmd(CMD_CLEAR_CUR));
    queue_cmd(random_cmd(4'd13));
    queue_cmd(random_cmd(4'd15));
    queue_cmd(random_cmd(CMD_CLEAR_CAT));
    queue_cmd(random_cmd(CMD_COUNT_ALL));
    queue_cmd(random_cmd(CMD_CLEAR_ALL));
    idle_pipeline();

    // Random phases; the catalog goes through its extremes and the ignored 15.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_catalog(4'd14);
        1: set_catalog(4'd15);
        2: set_catalog(4'd0);
        default: set_catalog(4'($urandom_range(0, 15)));
      endcase
      queue_cmd(random_cmd(CMD_FIRST));
      for (int n = 0; n < 70; n++) begin
        k = $urandom_range(0, 99);
        if (k < 25) begin
          // Well-formed: find a free slot and fill it.
          queue_cmd(random_cmd(CMD_FIRST_FREE));
          queue_cmd(random_cmd(CMD_WRITE));
          n++;
        end else if (k < 40) queue_cmd(random_cmd(CMD_READ));
        else if (k < 52) queue_cmd(random_cmd(CMD_NEXT));
        else if (k < 60) queue_cmd(random_cmd(CMD_PREV));
        else if (k < 66) queue_cmd(random_cmd(CMD_FIRST));
        else if (k < 71) queue_cmd(random_cmd(CMD_GOTO));
        else if (k < 75) queue_cmd(random_cmd(CMD_COUNT));
        else if (k < 78) queue_cmd(random_cmd(CMD_COUNT_ALL));
        else if (k < 81) queue_cmd(random_cmd(CMD_NAME_REC));
        else if (k < 86) queue_cmd(random_cmd(CMD_CLEAR_CUR));
        else if (k < 88) queue_cmd(random_cmd(CMD_CLEAR_CAT));
        else if (k < 89) queue_cmd(random_cmd(CMD_CLEAR_ALL));
        else if (k < 91) queue_cmd(random_cmd(4'($urandom_range(13, 15))));
        else queue_cmd(random_cmd(CMD_WRITE));
      end
      idle_pipeline();
    end

    $display("Ran %0d commands with %0d results across several catalog settings.",
             cmds_sent, results_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
